@@ hdl/vdt_pkg.sv @@
package vdt_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int WORD_W      = 32;
	localparam int WORDS       = 8;
	localparam int ROW_W       = WORD_W * WORDS;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W       = 8;
	localparam int FMT_W       = 2;

	typedef logic [ROW_W-1:0] row_t;
	typedef logic [WORDS-1:0] mask_t;

	typedef enum logic [FMT_W-1:0] {
		FMT_POS_NORMAL      = 2'd0,
		FMT_POS_TEX0_NORMAL = 2'd1,
		FMT_POS_TEX0_TEX1   = 2'd2,
		FMT_POS_COLOR       = 2'd3
	} fmt_t;

	// words taken part in the match for each vertex format
	function automatic mask_t cmp_mask(input fmt_t fmt);
		mask_t m;
		case (fmt)
			FMT_POS_NORMAL:      m = 8'b0011_1111;
			FMT_POS_TEX0_NORMAL: m = 8'b1111_1111;
			default:             m = 8'b0111_1111;
		endcase
		return m;
	endfunction

	function automatic logic word_is_nan(input logic [WORD_W-1:0] w);
		return w[WORD_W-2:0] > 31'h7F80_0000;
	endfunction

	// float equality: signed zeros match, NaN matches nothing
	function automatic logic float_eq(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
		logic both_zero;
		both_zero = ((a[WORD_W-2:0] | b[WORD_W-2:0]) == '0);
		return !word_is_nan(a) && !word_is_nan(b) && (both_zero || (a == b));
	endfunction

endpackage

@@ hdl/vertex_dedup_table_unit.sv @@
// Channel   Dir  Payload (low bit up)                              Transfer
// s_*       in   tdata: attr_0 .. attr_7, 32 bits each             tvalid & tready
// m_*       out  tdata: vertex_index[7:0]; tuser: was_new, full    tvalid & tready
// cfg_*     in   cfg_data: vertex_format[1:0]                      cfg_valid & cfg_ready
//
// One vertex is compared against the filled entries in order from entry 0, the scan stops at the
// first match or appends the vertex on a miss if there is room: one row is read and compared per cycle
// through a single row comparator behind a registered memory read, so the scan length sets the time to the result.
// s_tready is high only while the sequencer is idle; a held result does not block
// the next transfer, but a finished scan waits until the output register frees up.
// arst_n empties the table (fill count to zero) and sets vertex_format to 0.
module vertex_dedup_table_unit
	import vdt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [ROW_W-1:0] s_tdata,   // attr_0 .. attr_7
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [IDX_W-1:0] m_tdata,   // vertex_index
	output logic [1:0]       m_tuser,   // was_new, table_full
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [FMT_W-1:0] cfg_data   // vertex_format
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t             state_q;
	fmt_t               fmt_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   issue_q;
	row_t               vtx_q;
	mask_t              mask_q;
	row_t               row_s1;
	logic               pend_s1;
	logic [CNT_W-1:0]   idx_s1;
	logic [IDX_W-1:0]   res_idx_q;
	logic               res_new_q;
	logic               res_full_q;
	logic               m_tvalid_q;
	logic [IDX_W-1:0]   m_idx_q;
	logic               m_new_q;
	logic               m_full_q;

	row_t               mem [TABLE_DEPTH];

	logic               accept;
	logic               issue;
	logic               row_hit;
	logic               hit;
	logic               miss;
	logic               append;
	logic               out_free;
	logic               load_out;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;

	assign issue  = (state_q == ST_SCAN) && (issue_q < cnt_q);
	assign hit    = (state_q == ST_SCAN) && pend_s1 && row_hit;
	assign miss   = (state_q == ST_SCAN) && !issue && !pend_s1;
	assign append = miss && (cnt_q != CNT_W'(TABLE_DEPTH));

	assign out_free = !m_tvalid_q || m_tready;
	assign load_out = (state_q == ST_FINISH) && out_free;

	vdt_row_cmp u_cmp (
		.row  (row_s1),
		.vtx  (vtx_q),
		.mask (mask_q),
		.hit  (row_hit)
	);

	always_ff @(posedge clk) begin
		if (issue) begin
			row_s1 <= mem[issue_q[ADDR_W-1:0]];
		end
		if (append) begin
			mem[cnt_q[ADDR_W-1:0]] <= vtx_q;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= issue_q;
		if (accept) begin
			vtx_q  <= s_tdata;
			mask_q <= cmp_mask(fmt_q);
		end
		if (hit) begin
			res_idx_q  <= IDX_W'(idx_s1);
			res_new_q  <= 1'b0;
			res_full_q <= 1'b0;
		end else if (miss) begin
			res_idx_q  <= append ? IDX_W'(cnt_q) : '0;
			res_new_q  <= append;
			res_full_q <= !append;
		end
		if (load_out) begin
			m_idx_q  <= res_idx_q;
			m_new_q  <= res_new_q;
			m_full_q <= res_full_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fmt_q      <= FMT_POS_NORMAL;
			cnt_q      <= '0;
			issue_q    <= '0;
			pend_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				fmt_q <= fmt_t'(cfg_data);
			end
			pend_s1 <= issue && !hit;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					issue_q <= '0;
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit || miss) begin
						state_q <= ST_FINISH;
					end else if (issue) begin
						issue_q <= issue_q + 1'b1;
					end
					if (append) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FINISH: begin
					// hold the result until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_idx_q;
	assign m_tuser  = {m_full_q, m_new_q};

endmodule

@@ hdl/vdt_row_cmp.sv @@
module vdt_row_cmp
	import vdt_pkg::*;
(
	input  row_t  row,
	input  row_t  vtx,
	input  mask_t mask,
	output logic  hit
);

	mask_t word_ok;

	always_comb begin
		for (int k = 0; k < WORDS; k++) begin
			word_ok[k] = !mask[k] || float_eq(row[k*WORD_W +: WORD_W], vtx[k*WORD_W +: WORD_W]);
		end
	end

	assign hit = &word_ok;

endmodule

@@ hdl/vdt_checker.sv @@
module vdt_checker
	import vdt_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [IDX_W-1:0] m_tdata,
	input logic [1:0]       m_tuser
);

	// a stalled result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a dropped vertex is never reported as new and carries index zero
	a_full_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0] && (m_tdata == '0))
		else $error("full result with new flag or nonzero index");

	// one vertex at a time: ready drops right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second vertex taken during a scan");

endmodule

bind vertex_dedup_table_unit vdt_checker u_vdt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser)
);
